### design/radix2_fft_butterfly_macros.svh
// ----------------------------------------------------------------------------
// Radix-2 butterfly assertion macros
// Shared concurrent assertion forms, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef RADIX2_FFT_BUTTERFLY_MACROS_SVH
`define RADIX2_FFT_BUTTERFLY_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle (or as a sequence).
`define R2B_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define R2B_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/r2b_pkg.sv
// ----------------------------------------------------------------------------
// Radix-2 butterfly package
// Widths, register indexes, twiddle modes and pipeline control types.
// ----------------------------------------------------------------------------
`default_nettype none

package r2b_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int TWIDDLE_W      = 16;
    localparam int INDEX_W        = 12;
    localparam int HALF_W         = 13;
    localparam int OUT_W          = 18;
    localparam int PROD_W         = SAMPLE_W + TWIDDLE_W;
    localparam int ROUND_SHIFT    = 14;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = HALF_W;
    localparam logic [HALF_W-1:0] MAX_HALF_LENGTH = HALF_W'(4096);
    localparam logic [HALF_W-1:0] HALF_LENGTH_RST = HALF_W'(1);

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD     = 1'b1;

    typedef enum logic [1:0] {
        MODE_GENERAL,
        MODE_UNIT,
        MODE_QUARTER_FWD,
        MODE_QUARTER_INV
    } r2b_mode_t;

    typedef struct packed {
        logic      valid;
        r2b_mode_t mode;
    } r2b_ctl_t;

endpackage

`default_nettype wire

### design/r2b_cmul.sv
// ----------------------------------------------------------------------------
// Radix-2 butterfly twiddle rotator
// Two-stage W*O: registered 16x16 products, then combine, round half up
// to Q.15 and select the unit or quarter-turn bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module r2b_cmul
    import r2b_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  r2b_ctl_t                     in_ctl,
    input  wire signed [SAMPLE_W-1:0]    odd_real,
    input  wire signed [SAMPLE_W-1:0]    odd_imag,
    input  wire signed [TWIDDLE_W-1:0]   twiddle_real,
    input  wire signed [TWIDDLE_W-1:0]   twiddle_imag,
    output logic                         out_valid,
    output logic signed [OUT_W-1:0]      rot_real,
    output logic signed [OUT_W-1:0]      rot_imag
);

    r2b_ctl_t                    ctl_reg;
    logic signed [SAMPLE_W-1:0]  odd_real_reg;
    logic signed [SAMPLE_W-1:0]  odd_imag_reg;
    logic signed [PROD_W-1:0]    p_rr_reg;
    logic signed [PROD_W-1:0]    p_ii_reg;
    logic signed [PROD_W-1:0]    p_ri_reg;
    logic signed [PROD_W-1:0]    p_ir_reg;

    logic                        valid_reg;
    logic signed [OUT_W-1:0]     rot_real_reg;
    logic signed [OUT_W-1:0]     rot_imag_reg;
    logic signed [OUT_W-1:0]     rot_real_next;
    logic signed [OUT_W-1:0]     rot_imag_next;

    logic signed [PROD_W:0]      sum_real;
    logic signed [PROD_W:0]      sum_imag;
    logic signed [PROD_W:0]      rnd_real;
    logic signed [PROD_W:0]      rnd_imag;
    logic signed [OUT_W-1:0]     odd_real_x;
    logic signed [OUT_W-1:0]     odd_imag_x;

    // stage 2: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.valid <= 1'b0;
            ctl_reg.mode  <= MODE_GENERAL;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        odd_real_reg <= odd_real;
        odd_imag_reg <= odd_imag;
        p_rr_reg     <= odd_real * twiddle_real;
        p_ii_reg     <= odd_imag * twiddle_imag;
        p_ri_reg     <= odd_real * twiddle_imag;
        p_ir_reg     <= odd_imag * twiddle_real;
    end

    // stage 3: combine, round, bypass
    always_comb
    begin
        sum_real   = (PROD_W+1)'(p_rr_reg) - (PROD_W+1)'(p_ii_reg);
        sum_imag   = (PROD_W+1)'(p_ri_reg) + (PROD_W+1)'(p_ir_reg);
        rnd_real   = sum_real + (PROD_W+1)'(1 << (ROUND_SHIFT-1));
        rnd_imag   = sum_imag + (PROD_W+1)'(1 << (ROUND_SHIFT-1));
        odd_real_x = OUT_W'(odd_real_reg);
        odd_imag_x = OUT_W'(odd_imag_reg);
        case (ctl_reg.mode)
            MODE_UNIT:
            begin
                rot_real_next = odd_real_x;
                rot_imag_next = odd_imag_x;
            end
            MODE_QUARTER_FWD:
            begin
                rot_real_next = odd_imag_x;
                rot_imag_next = -odd_real_x;
            end
            MODE_QUARTER_INV:
            begin
                rot_real_next = -odd_imag_x;
                rot_imag_next = odd_real_x;
            end
            default:
            begin
                // outputs wrap to 18 bits, so the top bits can go here
                rot_real_next = rnd_real[ROUND_SHIFT +: OUT_W];
                rot_imag_next = rnd_imag[ROUND_SHIFT +: OUT_W];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_real_reg <= rot_real_next;
        rot_imag_reg <= rot_imag_next;
    end

    assign out_valid = valid_reg;
    assign rot_real  = rot_real_reg;
    assign rot_imag  = rot_imag_reg;

endmodule

`default_nettype wire

### design/radix2_fft_butterfly.sv
// ----------------------------------------------------------------------------
// Radix-2 DIT FFT butterfly
// top = E + W*O, bottom = E - W*O; Q1.15 samples, Q2.14 twiddles, Q3.15 out.
// ----------------------------------------------------------------------------
// One butterfly per clock. A beat taken on start appears on the outputs with
// done after passing four register stages in order: input capture and mode
// decode, the four 16x16 products, rounding of W*O, and the final add and
// subtract. busy stays low, so start is taken in every cycle, and results are
// shown for exactly one cycle. Index 0 uses a unit twiddle; with an even
// half_length, index half_length/2 rotates O by -i (forward) or +i (inverse).
// half_length writes above 4096 saturate to 4096.
`default_nettype none

module radix2_fft_butterfly
    import r2b_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_write,
    input  wire [CFG_INDEX_W-1:0]        cfg_index,
    input  wire [CFG_DATA_W-1:0]         cfg_data,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [SAMPLE_W-1:0]    even_real,
    input  wire signed [SAMPLE_W-1:0]    even_imag,
    input  wire signed [SAMPLE_W-1:0]    odd_real,
    input  wire signed [SAMPLE_W-1:0]    odd_imag,
    input  wire signed [TWIDDLE_W-1:0]   twiddle_real,
    input  wire signed [TWIDDLE_W-1:0]   twiddle_imag,
    input  wire [INDEX_W-1:0]            butterfly_index,
    output logic                         done,
    output logic signed [OUT_W-1:0]      top_real,
    output logic signed [OUT_W-1:0]      top_imag,
    output logic signed [OUT_W-1:0]      bottom_real,
    output logic signed [OUT_W-1:0]      bottom_imag
);

`include "radix2_fft_butterfly_macros.svh"

    logic [HALF_W-1:0]           half_length_reg;
    logic                        forward_reg;
    logic [HALF_W-1:0]           half_length_next;

    logic                        accept;
    logic                        quarter;
    r2b_ctl_t                    s1_ctl_next;
    r2b_ctl_t                    s1_ctl_reg;
    logic [INDEX_W-1:0]          s1_index_reg;
    logic signed [SAMPLE_W-1:0]  s1_er_reg;
    logic signed [SAMPLE_W-1:0]  s1_ei_reg;
    logic signed [SAMPLE_W-1:0]  s1_or_reg;
    logic signed [SAMPLE_W-1:0]  s1_oi_reg;
    logic signed [TWIDDLE_W-1:0] s1_wr_reg;
    logic signed [TWIDDLE_W-1:0] s1_wi_reg;

    logic signed [SAMPLE_W-1:0]  s2_er_reg;
    logic signed [SAMPLE_W-1:0]  s2_ei_reg;
    logic signed [SAMPLE_W-1:0]  s3_er_reg;
    logic signed [SAMPLE_W-1:0]  s3_ei_reg;

    logic                        s3_valid;
    logic signed [OUT_W-1:0]     rot_real;
    logic signed [OUT_W-1:0]     rot_imag;

    logic                        done_reg;
    logic signed [OUT_W-1:0]     top_real_reg;
    logic signed [OUT_W-1:0]     top_imag_reg;
    logic signed [OUT_W-1:0]     bottom_real_reg;
    logic signed [OUT_W-1:0]     bottom_imag_reg;

    // configuration
    assign half_length_next = (cfg_data > MAX_HALF_LENGTH) ? MAX_HALF_LENGTH : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_length_reg <= HALF_LENGTH_RST;
            forward_reg     <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HALF_LENGTH: half_length_reg <= half_length_next;
                REG_FORWARD:     forward_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // stage 1: capture and decode the twiddle mode
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        quarter = !half_length_reg[0] && (half_length_reg != '0)
                  && (butterfly_index == half_length_reg[HALF_W-1:1]);
        s1_ctl_next.valid = accept;
        if (butterfly_index == '0)
        begin
            s1_ctl_next.mode = MODE_UNIT;
        end
        else if (quarter)
        begin
            s1_ctl_next.mode = forward_reg ? MODE_QUARTER_FWD : MODE_QUARTER_INV;
        end
        else
        begin
            s1_ctl_next.mode = MODE_GENERAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg.valid <= 1'b0;
            s1_ctl_reg.mode  <= MODE_GENERAL;
        end
        else
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_index_reg <= butterfly_index;
        s1_er_reg    <= even_real;
        s1_ei_reg    <= even_imag;
        s1_or_reg    <= odd_real;
        s1_oi_reg    <= odd_imag;
        s1_wr_reg    <= twiddle_real;
        s1_wi_reg    <= twiddle_imag;
        s2_er_reg    <= s1_er_reg;
        s2_ei_reg    <= s1_ei_reg;
        s3_er_reg    <= s2_er_reg;
        s3_ei_reg    <= s2_ei_reg;
    end

    // stages 2 and 3: W*O
    r2b_cmul u_cmul (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ctl       (s1_ctl_reg),
        .odd_real     (s1_or_reg),
        .odd_imag     (s1_oi_reg),
        .twiddle_real (s1_wr_reg),
        .twiddle_imag (s1_wi_reg),
        .out_valid    (s3_valid),
        .rot_real     (rot_real),
        .rot_imag     (rot_imag)
    );

    // stage 4: add / subtract, wraps to 18 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s3_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        top_real_reg    <= OUT_W'(s3_er_reg) + rot_real;
        top_imag_reg    <= OUT_W'(s3_ei_reg) + rot_imag;
        bottom_real_reg <= OUT_W'(s3_er_reg) - rot_real;
        bottom_imag_reg <= OUT_W'(s3_ei_reg) - rot_imag;
    end

    assign done        = done_reg;
    assign top_real    = top_real_reg;
    assign top_imag    = top_imag_reg;
    assign bottom_real = bottom_real_reg;
    assign bottom_imag = bottom_imag_reg;

    // checks
    `R2B_ASSERT_IMPLIES(a_latency, clk, rst_n, accept, ##4 done, "accepted beat lost")
    `R2B_ASSERT_IMPLIES(a_no_phantom, clk, rst_n, done, $past(accept, 4), "result without beat")
    `R2B_ASSERT_IMPLIES(a_quarter_nonzero, clk, rst_n,
        s1_ctl_reg.valid && (s1_ctl_reg.mode == MODE_QUARTER_FWD || s1_ctl_reg.mode == MODE_QUARTER_INV),
        s1_index_reg != '0, "quarter rotation chosen at index zero")
    `R2B_ASSERT_NEXT(a_half_sat, clk, rst_n, cfg_write && cfg_index == REG_HALF_LENGTH,
        half_length_reg <= MAX_HALF_LENGTH, "half length beyond maximum")

endmodule

`default_nettype wire
